### rtl/pid_controller_position_increment_unit_defines.svh
// Assertion macros for the PID position/increment unit.
// Expects clk_i and rst_ni in the scope of use.
`ifndef PID_CONTROLLER_POSITION_INCREMENT_UNIT_DEFINES_SVH
`define PID_CONTROLLER_POSITION_INCREMENT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PIDPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pidpi check failed");

// Next-cycle implication.
`define PIDPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pidpi check failed");

`endif

### rtl/pidpi_pkg.sv
// Shared constants, codes and width helpers for the PID position/increment unit.
// No dependencies.
`timescale 1ns / 1ps

package pidpi_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int GAIN_INT_BITS      = 8;
  localparam int ACCUM_BITS         = 30;
  localparam int CFG_IDX_W          = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INT_GAIN   = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_DRIVE_MIN  = 3'd3,
    REG_DRIVE_MAX  = 3'd4,
    REG_ACCUM_LIM  = 3'd5,
    REG_DEAD_BAND  = 3'd6,
    REG_LOOP_FORM  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    FORM_POSITIONAL  = 1'b0,
    FORM_INCREMENTAL = 1'b1
  } loop_form_e;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // error sum is kept as ACCUM_BITS+2 signed bits
  function automatic int err_sum_width();
    return ACCUM_BITS + 2;
  endfunction

  // integral operand holds either the error sum or one error
  function automatic int op_i_width(input int sample_bits);
    return max2(ACCUM_BITS + 2, sample_bits + 1);
  endfunction

  function automatic int cfg_data_width(input int sample_bits, input int frac_bits);
    return max2(GAIN_INT_BITS + frac_bits, max2(ACCUM_BITS, sample_bits));
  endfunction

endpackage

### rtl/pidpi_err.sv
// Error stage: error, dead band, error-sum clamp and error history.
// Produces the three multiplier operands for either loop form. Uses pidpi_pkg.
`timescale 1ns / 1ps

module pidpi_err #(
  parameter int SAMPLE_BITS = pidpi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 load_i,
  input  logic signed [SAMPLE_BITS-1:0]                        setpoint_i,
  input  logic signed [SAMPLE_BITS-1:0]                        measured_i,
  input  logic        [SAMPLE_BITS-1:0]                        dead_band_i,
  input  logic        [pidpi_pkg::ACCUM_BITS-1:0]              accum_limit_i,
  input  pidpi_pkg::loop_form_e                                loop_form_i,
  output logic signed [SAMPLE_BITS+1:0]                        op_p_o,
  output logic signed [pidpi_pkg::op_i_width(SAMPLE_BITS)-1:0] op_i_o,
  output logic signed [SAMPLE_BITS+2:0]                        op_d_o
);
  import pidpi_pkg::*;

  localparam int E_W   = SAMPLE_BITS + 1;
  localparam int DE_W  = SAMPLE_BITS + 2;
  localparam int D2_W  = SAMPLE_BITS + 3;
  localparam int ES_W  = err_sum_width();
  localparam int OPI_W = op_i_width(SAMPLE_BITS);
  localparam int AC_W  = max2(ES_W, E_W) + 1;

  logic signed [E_W-1:0]   err_raw, err;
  logic        [E_W-1:0]   err_mag;
  logic signed [AC_W-1:0]  acc, acc_clamp, lim_pos, lim_neg;
  logic signed [ES_W-1:0]  err_sum_d, err_sum_q;
  logic signed [E_W-1:0]   last_q, ebl_q;
  logic signed [DE_W-1:0]  de;
  logic signed [D2_W-1:0]  d2e;
  logic signed [DE_W-1:0]  op_p_d, op_p_q;
  logic signed [OPI_W-1:0] op_i_d, op_i_q;
  logic signed [D2_W-1:0]  op_d_d, op_d_q;

  always_comb begin
    err_raw = E_W'(setpoint_i) - E_W'(measured_i);
    err_mag = err_raw[E_W-1] ? E_W'(-err_raw) : err_raw;
    err     = (err_mag < E_W'(dead_band_i)) ? '0 : err_raw;

    lim_pos = $signed(AC_W'(accum_limit_i));
    lim_neg = -lim_pos;
    acc     = AC_W'(err_sum_q) + AC_W'(err);
    if (acc < lim_neg) begin
      acc_clamp = lim_neg;
    end else if (acc > lim_pos) begin
      acc_clamp = lim_pos;
    end else begin
      acc_clamp = acc;
    end
    err_sum_d = ES_W'(acc_clamp);

    de  = DE_W'(err) - DE_W'(last_q);
    d2e = D2_W'(err) - (D2_W'(last_q) <<< 1) + D2_W'(ebl_q);

    if (loop_form_i == FORM_INCREMENTAL) begin
      op_p_d = de;
      op_i_d = OPI_W'(err);
      op_d_d = d2e;
    end else begin
      op_p_d = DE_W'(err);
      op_i_d = OPI_W'(err_sum_d);
      op_d_d = D2_W'(de);
    end
  end

  // error history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q <= '0;
      last_q    <= '0;
      ebl_q     <= '0;
    end else if (load_i) begin
      last_q <= err;
      if (loop_form_i == FORM_INCREMENTAL) begin
        ebl_q <= last_q;
      end else begin
        err_sum_q <= err_sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_p_q <= op_p_d;
      op_i_q <= op_i_d;
      op_d_q <= op_d_d;
    end
  end

  assign op_p_o = op_p_q;
  assign op_i_o = op_i_q;
  assign op_d_o = op_d_q;

endmodule

### rtl/pid_controller_position_increment_unit.sv
// PID controller, positional and incremental forms, fixed point (Q8.16 gains).
// The accept edge loads the request register, then the error stage, multiply stage and
// sum/clamp stage registers follow; drive_o is valid once the last of these is loaded.
// Throughput: one request per cycle unless out_stall_i holds the full pipe; the held
// output loop closes through one add-and-clamp in the last stage.
// Reset: async active low; config regs to defaults, error history and held output
// to zero, all stages empty.
`timescale 1ns / 1ps
`include "pid_controller_position_increment_unit_defines.svh"

module pid_controller_position_increment_unit #(
  parameter int SAMPLE_BITS    = pidpi_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pidpi_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // configuration
  input  logic                                        cfg_we_i,
  input  logic [pidpi_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [pidpi_pkg::cfg_data_width(SAMPLE_BITS, GAIN_FRAC_BITS)-1:0] cfg_data_i,
  // request channel
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]               setpoint_i,
  input  logic signed [SAMPLE_BITS-1:0]               measured_i,
  // result channel
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]               drive_o
);
  import pidpi_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int G      = GAIN_INT_BITS + GAIN_FRAC_BITS;
  localparam int OPI_W  = op_i_width(S);
  localparam int PP_W   = G + S + 2;
  localparam int PI_W   = G + OPI_W;
  localparam int PD_W   = G + S + 3;
  localparam int HELD_W = S + GAIN_FRAC_BITS;
  localparam int TOT_W  = max2(max2(PP_W, PI_W), max2(PD_W, HELD_W)) + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers, written only while the pipe is empty (user's duty, not enforced)
  // ---------------------------------------------------------------------------
  logic signed [G-1:0]          prop_gain_q, int_gain_q, deriv_gain_q;
  logic signed [S-1:0]          drive_min_q, drive_max_q;
  logic        [ACCUM_BITS-1:0] accum_limit_q;
  logic        [S-1:0]          dead_band_q;
  loop_form_e                   loop_form_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      int_gain_q    <= '0;
      deriv_gain_q  <= '0;
      drive_min_q   <= {1'b1, {(S-1){1'b0}}};
      drive_max_q   <= {1'b0, {(S-1){1'b1}}};
      accum_limit_q <= '1;
      dead_band_q   <= '0;
      loop_form_q   <= FORM_POSITIONAL;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:  prop_gain_q   <= cfg_data_i[G-1:0];
        REG_INT_GAIN:   int_gain_q    <= cfg_data_i[G-1:0];
        REG_DERIV_GAIN: deriv_gain_q  <= cfg_data_i[G-1:0];
        REG_DRIVE_MIN:  drive_min_q   <= cfg_data_i[S-1:0];
        REG_DRIVE_MAX:  drive_max_q   <= cfg_data_i[S-1:0];
        REG_ACCUM_LIM:  accum_limit_q <= cfg_data_i[ACCUM_BITS-1:0];
        REG_DEAD_BAND:  dead_band_q   <= cfg_data_i[S-1:0];
        REG_LOOP_FORM:  loop_form_q   <= loop_form_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage moves when the next one is free or
  // draining, so bubbles collapse; a waiting result stalls intake only once
  // all four stages hold requests.
  // ---------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;
  logic in_acc, mv01, mv12, mv23;

  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign in_stall_o = !rdy0;
  assign in_acc     = in_valid_i && rdy0;
  assign mv01       = v0_q && rdy1;
  assign mv12       = v1_q && rdy2;
  assign mv23       = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 0: request register
  logic signed [S-1:0] sp0_q, ms0_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sp0_q <= setpoint_i;
      ms0_q <= measured_i;
    end
  end

  // Stage 1: error, dead band, history; operands picked per loop form
  logic signed [S+1:0]     op_p;
  logic signed [OPI_W-1:0] op_i;
  logic signed [S+2:0]     op_d;

  pidpi_err #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_err (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (mv01),
    .setpoint_i    (sp0_q),
    .measured_i    (ms0_q),
    .dead_band_i   (dead_band_q),
    .accum_limit_i (accum_limit_q),
    .loop_form_i   (loop_form_q),
    .op_p_o        (op_p),
    .op_i_o        (op_i),
    .op_d_o        (op_d)
  );

  // Stage 2: three independent gain multiplies
  logic signed [PP_W-1:0] pp_d, pp_q;
  logic signed [PI_W-1:0] pi_d, pi_q;
  logic signed [PD_W-1:0] pd_d, pd_q;

  assign pp_d = PP_W'(prop_gain_q) * PP_W'(op_p);
  assign pi_d = PI_W'(int_gain_q) * PI_W'(op_i);
  assign pd_d = PD_W'(deriv_gain_q) * PD_W'(op_d);

  always_ff @(posedge clk_i) begin
    if (mv12) begin
      pp_q <= pp_d;
      pi_q <= pi_d;
      pd_q <= pd_d;
    end
  end

  // Stage 3: sum, output clamp, held output (also the result register)
  logic signed [TOT_W-1:0]  base, total, lo, hi, clamped;
  logic signed [HELD_W-1:0] held_q;

  always_comb begin
    base  = (loop_form_q == FORM_INCREMENTAL) ? TOT_W'(held_q) : '0;
    total = base + TOT_W'(pp_q) + TOT_W'(pi_q) + TOT_W'(pd_q);
    lo    = TOT_W'(drive_min_q) <<< GAIN_FRAC_BITS;
    hi    = TOT_W'(drive_max_q) <<< GAIN_FRAC_BITS;
    // min test wins when the range is inverted
    if (total < lo) begin
      clamped = lo;
    end else if (total > hi) begin
      clamped = hi;
    end else begin
      clamped = total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (mv23) begin
      held_q <= HELD_W'(clamped);
    end
  end

  assign out_valid_o = v3_q;
  assign drive_o     = held_q[HELD_W-1:GAIN_FRAC_BITS];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PIDPI_ASSERT_NOW(a_empty_out_takes_req, !out_valid_o, !in_stall_o)
  `PIDPI_ASSERT_NEXT(a_req_lands_stage0, in_valid_i && !in_stall_o, v0_q)
  `PIDPI_ASSERT_NEXT(a_drive_in_range,
                     mv23 && (drive_min_q <= drive_max_q),
                     (drive_o >= $signed($past(drive_min_q))) &&
                     (drive_o <= $signed($past(drive_max_q))))
  `PIDPI_ASSERT_NEXT(a_stage3_fills, mv23, out_valid_o)

endmodule

### tb/tb_pid_controller_position_increment_unit.sv
// Self-checking testbench for pid_controller_position_increment_unit: random and directed
// requests against a cycle-free predictor of the PID update, drive checked in order.
// Depends on pidpi_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_pid_controller_position_increment_unit;
  import pidpi_pkg::*;

  localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
  localparam int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF;
  localparam int GAIN_BITS      = GAIN_INT_BITS + GAIN_FRAC_BITS;
  localparam int CFG_W          = cfg_data_width(SAMPLE_BITS, GAIN_FRAC_BITS);
  localparam int CLK_PERIOD     = 20;
  // pipeline is 4 deep; settle allowance before register writes and at the end
  localparam int DRAIN_CYCLES   = 10;
  localparam int LONG_HOLD      = 80;
  localparam int HOLD_AFTER_REQ = 300;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] setpoint;
    logic signed [SAMPLE_BITS-1:0] measured;
  } sample_pair_t;

  // DUT ports, all known from time zero
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx_i   = '0;
  logic [CFG_W-1:0]              cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] setpoint_i  = '0;
  logic signed [SAMPLE_BITS-1:0] measured_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] drive_o;

  pid_controller_position_increment_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Controller predictor: private copy of the registers and loop state.
  // ---------------------------------------------------------------------------
  logic signed [GAIN_BITS-1:0]   kp_q;
  logic signed [GAIN_BITS-1:0]   ki_dt_q;
  logic signed [GAIN_BITS-1:0]   kd_dt_q;
  logic signed [SAMPLE_BITS-1:0] drive_lo_q;
  logic signed [SAMPLE_BITS-1:0] drive_hi_q;
  logic [ACCUM_BITS-1:0]         sum_limit_q;
  logic [SAMPLE_BITS-1:0]        dead_band_q;
  loop_form_e                    form_q;

  logic signed [ACCUM_BITS+1:0]  err_sum_q;
  logic signed [SAMPLE_BITS:0]   err_prev_q;
  logic signed [SAMPLE_BITS:0]   err_prev2_q;
  logic signed [31:0]            held_out_q;

  function automatic void reset_controller();
    kp_q        = '0;
    ki_dt_q     = '0;
    kd_dt_q     = '0;
    drive_lo_q  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    drive_hi_q  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    sum_limit_q = '1;
    dead_band_q = '0;
    form_q      = FORM_POSITIONAL;
    err_sum_q   = '0;
    err_prev_q  = '0;
    err_prev2_q = '0;
    held_out_q  = '0;
  endfunction

  // Register bits above each register's width are dropped here, as in the unit.
  function automatic void load_register(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    case (idx)
      REG_PROP_GAIN:  kp_q        = value[GAIN_BITS-1:0];
      REG_INT_GAIN:   ki_dt_q     = value[GAIN_BITS-1:0];
      REG_DERIV_GAIN: kd_dt_q     = value[GAIN_BITS-1:0];
      REG_DRIVE_MIN:  drive_lo_q  = value[SAMPLE_BITS-1:0];
      REG_DRIVE_MAX:  drive_hi_q  = value[SAMPLE_BITS-1:0];
      REG_ACCUM_LIM:  sum_limit_q = value[ACCUM_BITS-1:0];
      REG_DEAD_BAND:  dead_band_q = value[SAMPLE_BITS-1:0];
      REG_LOOP_FORM:  form_q      = loop_form_e'(value[0]);
      default: ;
    endcase
  endfunction

  // One control step: returns the drive the unit should emit for this request.
  function automatic logic signed [SAMPLE_BITS-1:0] step_controller(
      input logic signed [SAMPLE_BITS-1:0] sp,
      input logic signed [SAMPLE_BITS-1:0] ms);
    longint err;
    longint mag;
    longint acc;
    longint lim;
    longint total;
    longint lo;
    longint hi;
    err = longint'(sp) - longint'(ms);
    mag = (err < 0) ? -err : err;
    if (mag < longint'(dead_band_q)) err = 0;
    if (form_q == FORM_POSITIONAL) begin
      lim = longint'(sum_limit_q);
      acc = longint'(err_sum_q) + err;
      if (acc < -lim) acc = -lim;
      else if (acc > lim) acc = lim;
      err_sum_q = (ACCUM_BITS+2)'(acc);
      total = longint'(kp_q) * err
            + longint'(ki_dt_q) * longint'(err_sum_q)
            + longint'(kd_dt_q) * (err - longint'(err_prev_q));
    end else begin
      total = longint'(held_out_q)
            + longint'(kp_q) * (err - longint'(err_prev_q))
            + longint'(ki_dt_q) * err
            + longint'(kd_dt_q) * (err - 2 * longint'(err_prev_q) + longint'(err_prev2_q));
      err_prev2_q = err_prev_q;
    end
    err_prev_q = (SAMPLE_BITS+1)'(err);
    // low clamp takes priority when the range is inverted
    lo = longint'(drive_lo_q) * (longint'(1) << GAIN_FRAC_BITS);
    hi = longint'(drive_hi_q) * (longint'(1) << GAIN_FRAC_BITS);
    if (total < lo) total = lo;
    else if (total > hi) total = hi;
    held_out_q = 32'(total);
    // arithmetic shift floors toward minus infinity
    step_controller = SAMPLE_BITS'(held_out_q >>> GAIN_FRAC_BITS);
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  sample_pair_t                  pending_requests[$];
  logic signed [SAMPLE_BITS-1:0] expected_drive[$];
  int  mismatch_count  = 0;
  int  requests_taken  = 0;
  int  drives_checked  = 0;
  int  reg_writes      = 0;
  int  setting_count   = 0;
  bit  req_taken       = 1'b0;  // request accepted at the last rising edge
  bit  quiet_tail      = 1'b0;  // no idling on either side once set
  int  tx_idle_left    = 0;
  int  rx_idle_left    = 0;
  int  rx_hold_left    = 0;
  bit  long_hold_done  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: holds a request until taken, then either idles a burst
  // or presents the next pending request. Valid never looks at stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_requests
    sample_pair_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (tx_idle_left > 0) begin
        tx_idle_left--;
        in_valid_i <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt = pending_requests.pop_front();
        setpoint_i <= nxt.setpoint;
        measured_i <= nxt.measured;
        in_valid_i <= 1'b1;
        // gap before the request after this one
        if (!quiet_tail && $urandom_range(0, 5) == 0) tx_idle_left = $urandom_range(1, 8);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, plus one long hold partway through
  // so the pipeline fills and the unit has to stall its request side.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && requests_taken >= HOLD_AFTER_REQ) begin
      long_hold_done = 1'b1;
      rx_hold_left   = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (rx_idle_left > 0) begin
      rx_idle_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      rx_idle_left = $urandom_range(1, 8) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted request and checks every accepted
  // drive against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    logic signed [SAMPLE_BITS-1:0] want;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        req_taken = 1'b1;
        requests_taken++;
        expected_drive.push_back(step_controller(setpoint_i, measured_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_drive.size() == 0) begin
          report_mismatch($sformatf("drive %0d with no request outstanding", drive_o));
        end else begin
          want = expected_drive.pop_front();
          drives_checked++;
          if (drive_o !== want)
            report_mismatch($sformatf("drive %0d: got %0d, want %0d",
                                      drives_checked, drive_o, want));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    load_register(idx, value);
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Junk in the unused upper bits of each write checks that they are ignored.
  function automatic logic [CFG_W-1:0] with_junk(input int width, input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] junk;
    logic [CFG_W-1:0] keep;
    junk = CFG_W'($urandom);
    keep = CFG_W'((64'd1 << width) - 64'd1);
    return (junk & ~keep) | (v & keep);
  endfunction

  // Writes one whole setting; every register each time.
  task automatic apply_setting(input logic [GAIN_BITS-1:0] kp, input logic [GAIN_BITS-1:0] ki,
                               input logic [GAIN_BITS-1:0] kd, input int lo, input int hi,
                               input int unsigned lim, input int unsigned band,
                               input loop_form_e form);
    write_reg(REG_PROP_GAIN,  with_junk(GAIN_BITS, CFG_W'(kp)));
    write_reg(REG_INT_GAIN,   with_junk(GAIN_BITS, CFG_W'(ki)));
    write_reg(REG_DERIV_GAIN, with_junk(GAIN_BITS, CFG_W'(kd)));
    write_reg(REG_DRIVE_MIN,  with_junk(SAMPLE_BITS, CFG_W'(lo)));
    write_reg(REG_DRIVE_MAX,  with_junk(SAMPLE_BITS, CFG_W'(hi)));
    write_reg(REG_ACCUM_LIM,  with_junk(ACCUM_BITS, CFG_W'(lim)));
    write_reg(REG_DEAD_BAND,  with_junk(SAMPLE_BITS, CFG_W'(band)));
    write_reg(REG_LOOP_FORM,  with_junk(1, CFG_W'(form)));
    setting_count++;
  endtask

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    int g;
    case ($urandom_range(0, 6))
      0: g = 0;
      1: g = $urandom;
      2: g = $urandom_range(0, 1) ? (1 << (GAIN_BITS - 1)) : (1 << (GAIN_BITS - 1)) - 1;
      default: g = $urandom_range(0, 1 << 18) - (1 << 17);  // within +/-2.0
    endcase
    return GAIN_BITS'(g);
  endfunction

  task automatic apply_random_setting();
    int a;
    int b;
    int lo;
    int hi;
    int unsigned lim;
    int unsigned band;
    logic [GAIN_BITS-1:0] kp;
    logic [GAIN_BITS-1:0] ki;
    logic [GAIN_BITS-1:0] kd;
    kp = pick_gain();
    ki = pick_gain();
    kd = pick_gain();
    a = $urandom_range(0, 65535) - 32768;
    b = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 3))
      0: begin lo = -32768; hi = 32767; end
      1: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
      2: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end  // inverted range
      default: begin lo = -$urandom_range(0, 200); hi = $urandom_range(0, 200); end
    endcase
    case ($urandom_range(0, 3))
      0: lim = 0;
      1: lim = $urandom_range(0, 4000);
      2: lim = $urandom & 32'h3FFF_FFFF;
      default: lim = 32'h3FFF_FFFF;
    endcase
    case ($urandom_range(0, 5))
      0, 1: band = 0;
      2, 3: band = $urandom_range(0, 64);
      4: band = $urandom_range(0, 65535);
      default: band = 65535;
    endcase
    apply_setting(kp, ki, kd, lo, hi, lim, band, loop_form_e'($urandom_range(0, 1)));
  endtask

  function automatic void queue_request(input int sp, input int ms);
    sample_pair_t p;
    p.setpoint = SAMPLE_BITS'(sp);
    p.measured = SAMPLE_BITS'(ms);
    pending_requests.push_back(p);
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // Mostly a loop tracking its target (small errors), with full-range and
  // extreme samples mixed in.
  function automatic void queue_random_requests(input int n);
    int sp;
    int ms;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          sp = $urandom_range(0, 65535) - 32768;
          ms = $urandom_range(0, 65535) - 32768;
        end
        2: begin sp = pick_extreme(); ms = pick_extreme(); end
        default: begin
          sp = $urandom_range(0, 65535) - 32768;
          ms = sp + $urandom_range(0, 600) - 300;
          if (ms > 32767) ms = 32767;
          if (ms < -32768) ms = -32768;
        end
      endcase
      queue_request(sp, ms);
    end
  endfunction

  // Sender pause: nothing queued, nothing on the wire, nothing outstanding.
  task automatic wait_all_done();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_drive.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_controller();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Positional form, gains 1.0/0.25/0.5, full range, full-scale errors both ways.
    apply_setting(24'h01_0000, 24'h00_4000, 24'h00_8000, -32768, 32767, 1000, 0,
                  FORM_POSITIONAL);
    @(posedge clk_i);
    queue_request(32767, -32768);
    queue_request(-32768, 32767);
    queue_request(0, 0);
    queue_request(32767, 32767);
    queue_request(-32768, -32768);
    queue_request(100, -100);
    queue_request(-1, 0);
    wait_all_done();

    // Incremental form, dead band at its edge, inverted drive range.
    apply_setting(24'h02_0000, 24'h00_4000, 24'h00_8000, 100, -100, 0, 10,
                  FORM_INCREMENTAL);
    @(posedge clk_i);
    queue_request(5, 0);
    queue_request(10, 0);
    queue_request(-9, 0);
    queue_request(-10, 0);
    queue_request(32767, -32768);
    queue_request(-32768, 32767);
    queue_request(0, 0);
    wait_all_done();

    // Extreme gains, widest error sum, dead band at its top.
    apply_setting(24'h80_0000, 24'h7F_FFFF, 24'h80_0000, -32768, 32767, 32'h3FFF_FFFF,
                  65535, FORM_POSITIONAL);
    @(posedge clk_i);
    queue_request(32767, -32768);
    queue_request(-32768, 32767);
    queue_request(1, 2);
    queue_request(0, 0);
    wait_all_done();

    // Extreme gains in incremental form, no dead band.
    apply_setting(24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, -32768, 32767, 32'h3FFF_FFFF,
                  0, FORM_INCREMENTAL);
    @(posedge clk_i);
    queue_request(32767, -32768);
    queue_request(-32768, 32767);
    queue_request(0, 0);
    queue_request(12, -7);
    wait_all_done();

    // Random settings, each followed by a random stream; the last runs flat out.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) quiet_tail = 1'b1;
      apply_random_setting();
      @(posedge clk_i);
      queue_random_requests(130);
      wait_all_done();
    end

    $display("covered %0d requests, %0d drives checked, %0d register writes, %0d settings",
             requests_taken, drives_checked, reg_writes, setting_count);
    $display("both loop forms, dead band, inverted and narrow ranges, long output hold");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("timeout: %0d drives still outstanding", expected_drive.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
